[src/source_tokenizer_assert.svh]
// assertion macros used by the checker file
`ifndef SOURCE_TOKENIZER_ASSERT_SVH
`define SOURCE_TOKENIZER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SRCTOK_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SRCTOK_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/srctok_pkg.sv]
package srctok_pkg;

    localparam int LINE_FIELD_W = 20;
    localparam int COL_FIELD_W  = 16;
    localparam int MAX_RES      = 3;
    localparam int CNT_W        = $clog2(MAX_RES + 1);
    localparam int IDX_W        = $clog2(MAX_RES);
    localparam int QUEUE_DEPTH  = 2;

    // record kinds
    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // token types
    localparam logic [3:0] TOK_DEF    = 4'd0;
    localparam logic [3:0] TOK_VOID   = 4'd1;
    localparam logic [3:0] TOK_INT    = 4'd2;
    localparam logic [3:0] TOK_FLOAT  = 4'd3;
    localparam logic [3:0] TOK_STR    = 4'd4;
    localparam logic [3:0] TOK_RET    = 4'd5;
    localparam logic [3:0] TOK_IDENT  = 4'd6;
    localparam logic [3:0] TOK_NUMBER = 4'd7;
    localparam logic [3:0] TOK_STRING = 4'd8;
    localparam logic [3:0] TOK_LPAREN = 4'd9;
    localparam logic [3:0] TOK_RPAREN = 4'd10;
    localparam logic [3:0] TOK_LBRACE = 4'd11;
    localparam logic [3:0] TOK_RBRACE = 4'd12;
    localparam logic [3:0] TOK_ARROW  = 4'd13;
    localparam logic [3:0] TOK_SEMI   = 4'd14;

    // error records carry no token type
    localparam logic [3:0] TOK_NONE   = 4'd0;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_NL_IN_STR  = 2'd1;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd2;
    localparam logic [1:0] ERR_STR_OPEN   = 2'd3;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STRING,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_MINUS
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_source;
    } src_item_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [3:0]              tok_type;
        logic [7:0]              value_byte;
        logic [1:0]              err_code;
        logic [LINE_FIELD_W-1:0] start_line;
        logic [COL_FIELD_W-1:0]  start_col;
        logic                    last_of_run;
    } tok_item_t;

    // all records caused by one source byte
    typedef struct packed {
        tok_item_t [MAX_RES-1:0] recs;
        logic [CNT_W-1:0]        count;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[src/srctok_front.sv]
module srctok_front #(
    parameter int LINE_WIDTH = 20,
    parameter int COL_WIDTH  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   src_valid,
    output logic                   src_stall,
    input  srctok_pkg::src_item_t  src_item,
    input  srctok_pkg::q_status_t  q_status,
    output logic                   push,
    output srctok_pkg::bundle_t    push_data
);

    localparam int LW = srctok_pkg::LINE_FIELD_W;
    localparam int CW = srctok_pkg::COL_FIELD_W;
    localparam int LX = (LINE_WIDTH > LW) ? LINE_WIDTH : LW;
    localparam int CX = (COL_WIDTH > CW) ? COL_WIDTH : CW;
    localparam int KW_BYTES = 5;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    srctok_pkg::scan_mode_t mode_reg, mode_next;
    logic [LINE_WIDTH-1:0]  line_reg, line_next;
    logic [COL_WIDTH-1:0]   col_reg, col_next;
    logic [LW-1:0]          tok_line_reg, tok_line_next;
    logic [CW-1:0]          tok_col_reg, tok_col_next;
    logic [KW_BYTES-1:0][7:0] kw_reg, kw_next;
    logic [2:0]             len_reg, len_next;

    logic                   accept;
    logic [7:0]             c;
    logic [LW-1:0]          ln;
    logic [CW-1:0]          cl;
    logic                   do_start;
    logic [srctok_pkg::CNT_W-1:0] n;
    srctok_pkg::tok_item_t [srctok_pkg::MAX_RES-1:0] recs;

    function automatic logic is_digit(logic [7:0] x);
        return (x >= 8'h30) && (x <= 8'h39);
    endfunction

    function automatic logic is_ident_start(logic [7:0] x);
        return ((x >= 8'h61) && (x <= 8'h7A)) || ((x >= 8'h41) && (x <= 8'h5A))
            || (x == CH_UNDER);
    endfunction

    function automatic logic is_ident_char(logic [7:0] x);
        return is_ident_start(x) || is_digit(x);
    endfunction

    function automatic logic [3:0] ident_type(logic [KW_BYTES-1:0][7:0] kw, logic [2:0] len);
        logic [3:0] t;
        t = srctok_pkg::TOK_IDENT;
        if (len == 3'd3 && kw[2:0] == {"f", "e", "d"})
            t = srctok_pkg::TOK_DEF;
        else if (len == 3'd4 && kw[3:0] == {"d", "i", "o", "v"})
            t = srctok_pkg::TOK_VOID;
        else if (len == 3'd3 && kw[2:0] == {"t", "n", "i"})
            t = srctok_pkg::TOK_INT;
        else if (len == 3'd5 && kw[4:0] == {"t", "a", "o", "l", "f"})
            t = srctok_pkg::TOK_FLOAT;
        else if (len == 3'd3 && kw[2:0] == {"r", "t", "s"})
            t = srctok_pkg::TOK_STR;
        else if (len == 3'd3 && kw[2:0] == {"t", "e", "r"})
            t = srctok_pkg::TOK_RET;
        return t;
    endfunction

    function automatic logic [LW-1:0] clamp_line(logic [LINE_WIDTH-1:0] v);
        logic [LX-1:0] w;
        w = LX'(v);
        if (w > LX'({LW{1'b1}}))
            return '1;
        return w[LW-1:0];
    endfunction

    function automatic logic [CW-1:0] clamp_col(logic [COL_WIDTH-1:0] v);
        logic [CX-1:0] w;
        w = CX'(v);
        if (w > CX'({CW{1'b1}}))
            return '1;
        return w[CW-1:0];
    endfunction

    function automatic srctok_pkg::tok_item_t mk(logic [1:0] k, logic [3:0] t,
                                                 logic [7:0] v, logic [1:0] e,
                                                 logic [LW-1:0] l, logic [CW-1:0] cc);
        srctok_pkg::tok_item_t r;
        r.kind        = k;
        r.tok_type    = t;
        r.value_byte  = v;
        r.err_code    = e;
        r.start_line  = l;
        r.start_col   = cc;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    assign accept    = src_valid && !q_status.full;
    assign src_stall = q_status.full;
    assign c         = src_item.ch;
    assign ln        = clamp_line(line_reg);
    assign cl        = clamp_col(col_reg);

    always_comb
    begin
        mode_next     = mode_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        kw_next       = kw_reg;
        len_next      = len_reg;
        do_start      = 1'b0;
        n             = '0;
        recs          = '0;

        // finish or extend the open token
        unique case (mode_reg)
            srctok_pkg::MODE_STRING:
            begin
                if (c == CH_QUOTE)
                begin
                    recs[n] = mk(srctok_pkg::KIND_DONE, srctok_pkg::TOK_STRING, 8'h00,
                                 srctok_pkg::ERR_NONE, tok_line_reg, tok_col_reg);
                    mode_next = srctok_pkg::MODE_IDLE;
                end
                else if (c == CH_NL)
                    recs[n] = mk(srctok_pkg::KIND_ERROR, srctok_pkg::TOK_NONE, CH_NL,
                                 srctok_pkg::ERR_NL_IN_STR, tok_line_reg, tok_col_reg);
                else
                    recs[n] = mk(srctok_pkg::KIND_VALUE, srctok_pkg::TOK_STRING, c,
                                 srctok_pkg::ERR_NONE, tok_line_reg, tok_col_reg);
                n = n + 1'b1;
            end
            srctok_pkg::MODE_NUMBER:
            begin
                if (is_digit(c))
                    recs[n] = mk(srctok_pkg::KIND_VALUE, srctok_pkg::TOK_NUMBER, c,
                                 srctok_pkg::ERR_NONE, tok_line_reg, tok_col_reg);
                else
                begin
                    recs[n] = mk(srctok_pkg::KIND_DONE, srctok_pkg::TOK_NUMBER, 8'h00,
                                 srctok_pkg::ERR_NONE, tok_line_reg, tok_col_reg);
                    mode_next = srctok_pkg::MODE_IDLE;
                    do_start  = 1'b1;
                end
                n = n + 1'b1;
            end
            srctok_pkg::MODE_IDENT:
            begin
                if (is_ident_char(c))
                begin
                    for (int i = 0; i < KW_BYTES; i++)
                        if (len_reg == 3'(i))
                            kw_next[i] = c;
                    if (len_reg < 3'd6)
                        len_next = len_reg + 3'd1;
                    recs[n] = mk(srctok_pkg::KIND_VALUE, srctok_pkg::TOK_IDENT, c,
                                 srctok_pkg::ERR_NONE, tok_line_reg, tok_col_reg);
                end
                else
                begin
                    recs[n] = mk(srctok_pkg::KIND_DONE, ident_type(kw_reg, len_reg), 8'h00,
                                 srctok_pkg::ERR_NONE, tok_line_reg, tok_col_reg);
                    mode_next = srctok_pkg::MODE_IDLE;
                    do_start  = 1'b1;
                end
                n = n + 1'b1;
            end
            srctok_pkg::MODE_MINUS:
            begin
                mode_next = srctok_pkg::MODE_IDLE;
                if (c == CH_GT)
                    recs[n] = mk(srctok_pkg::KIND_DONE, srctok_pkg::TOK_ARROW, 8'h00,
                                 srctok_pkg::ERR_NONE, tok_line_reg, tok_col_reg);
                else
                begin
                    recs[n] = mk(srctok_pkg::KIND_ERROR, srctok_pkg::TOK_NONE, CH_MINUS,
                                 srctok_pkg::ERR_UNEXPECTED, tok_line_reg, tok_col_reg);
                    do_start = 1'b1;
                end
                n = n + 1'b1;
            end
            srctok_pkg::MODE_IDLE:
                do_start = 1'b1;
            default:
            begin
                mode_next = srctok_pkg::MODE_IDLE;
                do_start  = 1'b1;
            end
        endcase

        // byte begins a new item
        if (do_start)
        begin
            priority if (c == CH_QUOTE)
            begin
                mode_next     = srctok_pkg::MODE_STRING;
                tok_line_next = ln;
                tok_col_next  = cl;
            end
            else if (c == CH_SPACE || c == CH_TAB || c == CH_NL)
            begin
            end
            else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE
                     || c == CH_RBRACE || c == CH_SEMI)
            begin
                recs[n] = mk(srctok_pkg::KIND_DONE,
                             (c == CH_LPAREN) ? srctok_pkg::TOK_LPAREN :
                             (c == CH_RPAREN) ? srctok_pkg::TOK_RPAREN :
                             (c == CH_LBRACE) ? srctok_pkg::TOK_LBRACE :
                             (c == CH_RBRACE) ? srctok_pkg::TOK_RBRACE :
                                                srctok_pkg::TOK_SEMI,
                             8'h00, srctok_pkg::ERR_NONE, ln, cl);
                n = n + 1'b1;
            end
            else if (c == CH_MINUS)
            begin
                mode_next     = srctok_pkg::MODE_MINUS;
                tok_line_next = ln;
                tok_col_next  = cl;
            end
            else if (is_digit(c))
            begin
                mode_next     = srctok_pkg::MODE_NUMBER;
                tok_line_next = ln;
                tok_col_next  = cl;
                recs[n] = mk(srctok_pkg::KIND_VALUE, srctok_pkg::TOK_NUMBER, c,
                             srctok_pkg::ERR_NONE, ln, cl);
                n = n + 1'b1;
            end
            else if (is_ident_start(c))
            begin
                mode_next     = srctok_pkg::MODE_IDENT;
                tok_line_next = ln;
                tok_col_next  = cl;
                kw_next       = '0;
                kw_next[0]    = c;
                len_next      = 3'd1;
                recs[n] = mk(srctok_pkg::KIND_VALUE, srctok_pkg::TOK_IDENT, c,
                             srctok_pkg::ERR_NONE, ln, cl);
                n = n + 1'b1;
            end
            else
            begin
                recs[n] = mk(srctok_pkg::KIND_ERROR, srctok_pkg::TOK_NONE, c,
                             srctok_pkg::ERR_UNEXPECTED, ln, cl);
                n = n + 1'b1;
            end
        end

        // position counters, saturating
        if (c == CH_NL)
        begin
            if (line_reg != '1)
                line_next = line_reg + 1'b1;
            col_next = COL_WIDTH'(1);
        end
        else if (col_reg != '1)
            col_next = col_reg + 1'b1;

        // end of source flushes the open token
        if (src_item.end_of_source)
        begin
            unique case (mode_next)
                srctok_pkg::MODE_STRING:
                begin
                    recs[n] = mk(srctok_pkg::KIND_ERROR, srctok_pkg::TOK_NONE, 8'h00,
                                 srctok_pkg::ERR_STR_OPEN, tok_line_next, tok_col_next);
                    n = n + 1'b1;
                end
                srctok_pkg::MODE_NUMBER:
                begin
                    recs[n] = mk(srctok_pkg::KIND_DONE, srctok_pkg::TOK_NUMBER, 8'h00,
                                 srctok_pkg::ERR_NONE, tok_line_next, tok_col_next);
                    n = n + 1'b1;
                end
                srctok_pkg::MODE_IDENT:
                begin
                    recs[n] = mk(srctok_pkg::KIND_DONE, ident_type(kw_next, len_next), 8'h00,
                                 srctok_pkg::ERR_NONE, tok_line_next, tok_col_next);
                    n = n + 1'b1;
                end
                srctok_pkg::MODE_MINUS:
                begin
                    recs[n] = mk(srctok_pkg::KIND_ERROR, srctok_pkg::TOK_NONE, CH_MINUS,
                                 srctok_pkg::ERR_UNEXPECTED, tok_line_next, tok_col_next);
                    n = n + 1'b1;
                end
                default:
                begin
                end
            endcase
            mode_next = srctok_pkg::MODE_IDLE;
            line_next = LINE_WIDTH'(1);
            col_next  = COL_WIDTH'(1);
        end

        if (n != '0)
            recs[n - 1'b1].last_of_run = 1'b1;
    end

    assign push            = accept && (n != '0);
    assign push_data.recs  = recs;
    assign push_data.count = n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= srctok_pkg::MODE_IDLE;
            line_reg     <= LINE_WIDTH'(1);
            col_reg      <= COL_WIDTH'(1);
            tok_line_reg <= LW'(1);
            tok_col_reg  <= CW'(1);
            kw_reg       <= '0;
            len_reg      <= '0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            kw_reg       <= kw_next;
            len_reg      <= len_next;
        end
    end

endmodule

[src/srctok_queue.sv]
module srctok_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  srctok_pkg::bundle_t   push_data,
    input  logic                  pop,
    output srctok_pkg::q_status_t q_status,
    output srctok_pkg::bundle_t   head
);

    localparam int DEPTH = srctok_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    srctok_pkg::bundle_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign q_status.full  = (count_reg == (AW + 1)'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = mem_reg[rd_ptr_reg];

endmodule

[src/srctok_back.sv]
module srctok_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  srctok_pkg::q_status_t q_status,
    input  srctok_pkg::bundle_t   head,
    output logic                  pop,
    output logic                  tok_valid,
    input  logic                  tok_stall,
    output srctok_pkg::tok_item_t tok_item
);

    localparam int IW = srctok_pkg::IDX_W;
    localparam int NW = srctok_pkg::CNT_W;

    logic [IW-1:0]         idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    srctok_pkg::tok_item_t out_reg, out_next;
    logic                  load;
    logic                  last;

    // take the next record whenever the output register is free or draining and the queue holds a bundle
    assign load = (!valid_reg || !tok_stall) && !q_status.empty;
    assign last = ((NW'(idx_reg) + NW'(1)) == head.count);
    assign pop  = load && last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        if (load)
        begin
            out_next   = head.recs[idx_reg];
            valid_next = 1'b1;
            idx_next   = last ? '0 : idx_reg + 1'b1;
        end
        else if (!tok_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign tok_valid = valid_reg;
    assign tok_item  = out_reg;

endmodule

[src/source_tokenizer.sv]
// channel | direction | payload     | handshake
// src     | in        | src_item_t  | src_valid / src_stall, byte taken when valid and not stall
// tok     | out       | tok_item_t  | tok_valid / tok_stall, record taken when valid and not stall
//
// the front scans one source byte per cycle while the bundle queue has room
// the back hands out one record per cycle while tok_stall is low and the queue holds a bundle
// after its byte is taken, a record passes through the bundle queue and then the output register
// reset clears the scanner to idle with line and column at 1 and empties the queue
// tok_stall holds the output register; two full bundles in the queue raise src_stall
module source_tokenizer #(
    parameter int LINE_WIDTH = 20,
    parameter int COL_WIDTH  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  srctok_pkg::src_item_t src_item,
    output logic                  tok_valid,
    input  logic                  tok_stall,
    output srctok_pkg::tok_item_t tok_item
);

    // queue status is shared by both sides
    srctok_pkg::q_status_t q_status;
    srctok_pkg::bundle_t   push_data;
    srctok_pkg::bundle_t   head;
    logic                  push;
    logic                  pop;

    // front: scanner state, keyword buffer and position counters
    srctok_front #(
        .LINE_WIDTH (LINE_WIDTH),
        .COL_WIDTH  (COL_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // short queue of per-byte record bundles, lets each side stall on its own
    srctok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_status  (q_status),
        .head      (head)
    );

    // back: walks each bundle, one record per transaction
    srctok_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

endmodule

[src/srctok_checker.sv]
`include "source_tokenizer_assert.svh"

module srctok_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  src_valid,
    input logic                  src_stall,
    input srctok_pkg::src_item_t src_item,
    input logic                  tok_valid,
    input logic                  tok_stall,
    input srctok_pkg::tok_item_t tok_item
);

    `SRCTOK_ASSERT_NXT(a_out_hold, tok_valid && tok_stall, tok_valid && $stable(tok_item), "stalled record changed")

    `SRCTOK_ASSERT_IMP(a_pos_nonzero, tok_valid, (tok_item.start_line != '0) && (tok_item.start_col != '0), "record position is zero")

    `SRCTOK_ASSERT_IMP(a_value_class, tok_valid && (tok_item.kind == srctok_pkg::KIND_VALUE), (tok_item.err_code == srctok_pkg::ERR_NONE) && ((tok_item.tok_type == srctok_pkg::TOK_IDENT) || (tok_item.tok_type == srctok_pkg::TOK_NUMBER) || (tok_item.tok_type == srctok_pkg::TOK_STRING)), "value byte with bad class")

    `SRCTOK_ASSERT_IMP(a_done_clean, tok_valid && (tok_item.kind == srctok_pkg::KIND_DONE), (tok_item.value_byte == 8'h00) && (tok_item.err_code == srctok_pkg::ERR_NONE), "completion record carries data")

endmodule

bind source_tokenizer srctok_checker u_srctok_checker (.*);

[dv/tb_source_tokenizer.sv]
`timescale 1ns / 1ps

module tb_source_tokenizer;

    localparam int LINE_W       = srctok_pkg::LINE_FIELD_W;
    localparam int COL_W        = srctok_pkg::COL_FIELD_W;
    localparam int RANDOM_BYTES = 150;   // source bytes in the random part
    localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction before giving up
    localparam int DRAIN_CYCLES = 16;    // wait after the last record is checked, leave margin

    // error records carry no token type
    localparam logic [3:0] TYPE_NONE = srctok_pkg::TOK_NONE;

    logic                  clk;
    logic                  rst_n;
    logic                  src_valid;
    logic                  src_stall;
    srctok_pkg::src_item_t src_item;
    logic                  tok_valid;
    logic                  tok_stall;
    srctok_pkg::tok_item_t tok_item;

    // scanner copy kept by the testbench
    srctok_pkg::scan_mode_t lex_mode;
    logic [LINE_W-1:0]      cur_line;
    logic [COL_W-1:0]       cur_col;
    logic [LINE_W-1:0]      tok_line;
    logic [COL_W-1:0]       tok_col;
    logic [7:0]             kw_buf [5];
    logic [2:0]             id_len;

    // records caused by the byte being scanned, then all records still owed
    srctok_pkg::tok_item_t byte_tokens [$];
    srctok_pkg::tok_item_t pending_tokens [$];

    // source text built up before it is sent
    logic [7:0] source_text [$];

    string      kw_names [6] = '{"def", "void", "int", "float", "str", "ret"};
    logic [3:0] kw_types [6] = '{srctok_pkg::TOK_DEF, srctok_pkg::TOK_VOID,
                                 srctok_pkg::TOK_INT, srctok_pkg::TOK_FLOAT,
                                 srctok_pkg::TOK_STR, srctok_pkg::TOK_RET};
    string      ident_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string      punct_chars  = "(){};";
    string      blank_chars  = " \t\n";

    bit no_idle;
    int bytes_sent;
    int busy_bytes;
    int sources_sent;
    int records_checked;
    int failures;

    source_tokenizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // scanner prediction
    // ------------------------------------------------------------------

    function automatic void reset_scanner();
        lex_mode = srctok_pkg::MODE_IDLE;
        cur_line = LINE_W'(1);
        cur_col  = COL_W'(1);
        tok_line = LINE_W'(1);
        tok_col  = COL_W'(1);
        foreach (kw_buf[i])
            kw_buf[i] = 8'h00;
        id_len = 3'd0;
    endfunction

    // at most three records per byte, extra ones are dropped
    function automatic void add_token(logic [1:0] kind, logic [3:0] ttype, logic [7:0] vb,
                                      logic [1:0] err, logic [LINE_W-1:0] ln,
                                      logic [COL_W-1:0] cl);
        srctok_pkg::tok_item_t r;
        r.kind        = kind;
        r.tok_type    = ttype;
        r.value_byte  = vb;
        r.err_code    = err;
        r.start_line  = ln;
        r.start_col   = cl;
        r.last_of_run = 1'b0;
        if (byte_tokens.size() < srctok_pkg::MAX_RES)
            byte_tokens.insert(byte_tokens.size(), r);
    endfunction

    function automatic void close_token(logic [3:0] ttype);
        add_token(srctok_pkg::KIND_DONE, ttype, 8'h00, srctok_pkg::ERR_NONE, tok_line, tok_col);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_ident_start(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // keyword buffer keeps the first five bytes, length saturates at six
    function automatic void ident_add(logic [7:0] c);
        if (id_len < 3'd5)
            kw_buf[id_len] = c;
        if (id_len < 3'd6)
            id_len++;
    endfunction

    function automatic logic [3:0] ident_type();
        bit same;
        for (int k = 0; k < 6; k++)
        begin
            same = (int'(id_len) == kw_names[k].len());
            for (int i = 0; i < kw_names[k].len(); i++)
                if (same && kw_buf[i] != kw_names[k][i])
                    same = 1'b0;
            if (same)
                return kw_types[k];
        end
        return srctok_pkg::TOK_IDENT;
    endfunction

    // byte seen with the scanner idle
    function automatic void open_token(logic [7:0] c, logic [LINE_W-1:0] ln,
                                       logic [COL_W-1:0] cl);
        case (c)
            "\"":
            begin
                lex_mode = srctok_pkg::MODE_STRING;
                tok_line = ln;
                tok_col  = cl;
            end
            " ", "\t", "\n": ;
            "(": add_token(srctok_pkg::KIND_DONE, srctok_pkg::TOK_LPAREN, 8'h00,
                           srctok_pkg::ERR_NONE, ln, cl);
            ")": add_token(srctok_pkg::KIND_DONE, srctok_pkg::TOK_RPAREN, 8'h00,
                           srctok_pkg::ERR_NONE, ln, cl);
            "{": add_token(srctok_pkg::KIND_DONE, srctok_pkg::TOK_LBRACE, 8'h00,
                           srctok_pkg::ERR_NONE, ln, cl);
            "}": add_token(srctok_pkg::KIND_DONE, srctok_pkg::TOK_RBRACE, 8'h00,
                           srctok_pkg::ERR_NONE, ln, cl);
            ";": add_token(srctok_pkg::KIND_DONE, srctok_pkg::TOK_SEMI, 8'h00,
                           srctok_pkg::ERR_NONE, ln, cl);
            "-":
            begin
                lex_mode = srctok_pkg::MODE_MINUS;
                tok_line = ln;
                tok_col  = cl;
            end
            default:
            begin
                if (is_digit(c))
                begin
                    lex_mode = srctok_pkg::MODE_NUMBER;
                    tok_line = ln;
                    tok_col  = cl;
                    add_token(srctok_pkg::KIND_VALUE, srctok_pkg::TOK_NUMBER, c,
                              srctok_pkg::ERR_NONE, ln, cl);
                end
                else if (is_ident_start(c))
                begin
                    lex_mode = srctok_pkg::MODE_IDENT;
                    tok_line = ln;
                    tok_col  = cl;
                    foreach (kw_buf[i])
                        kw_buf[i] = 8'h00;
                    id_len = 3'd0;
                    ident_add(c);
                    add_token(srctok_pkg::KIND_VALUE, srctok_pkg::TOK_IDENT, c,
                              srctok_pkg::ERR_NONE, ln, cl);
                end
                else
                begin
                    add_token(srctok_pkg::KIND_ERROR, TYPE_NONE, c,
                              srctok_pkg::ERR_UNEXPECTED, ln, cl);
                end
            end
        endcase
    endfunction

    // one accepted source byte: queue every record it owes
    function automatic void scan_byte(srctok_pkg::src_item_t item);
        logic [7:0]            c;
        logic [LINE_W-1:0]     ln;
        logic [COL_W-1:0]      cl;
        srctok_pkg::tok_item_t last;
        c  = item.ch;
        ln = cur_line;
        cl = cur_col;
        byte_tokens.delete();

        case (lex_mode)
            srctok_pkg::MODE_STRING:
            begin
                if (c == "\"")
                begin
                    close_token(srctok_pkg::TOK_STRING);
                    lex_mode = srctok_pkg::MODE_IDLE;
                end
                else if (c == "\n")
                begin
                    // newline inside a string is flagged, the string goes on
                    add_token(srctok_pkg::KIND_ERROR, TYPE_NONE, "\n",
                              srctok_pkg::ERR_NL_IN_STR, tok_line, tok_col);
                end
                else
                begin
                    add_token(srctok_pkg::KIND_VALUE, srctok_pkg::TOK_STRING, c,
                              srctok_pkg::ERR_NONE, tok_line, tok_col);
                end
            end
            srctok_pkg::MODE_NUMBER:
            begin
                if (is_digit(c))
                begin
                    add_token(srctok_pkg::KIND_VALUE, srctok_pkg::TOK_NUMBER, c,
                              srctok_pkg::ERR_NONE, tok_line, tok_col);
                end
                else
                begin
                    close_token(srctok_pkg::TOK_NUMBER);
                    lex_mode = srctok_pkg::MODE_IDLE;
                    open_token(c, ln, cl);
                end
            end
            srctok_pkg::MODE_IDENT:
            begin
                if (is_ident_start(c) || is_digit(c))
                begin
                    ident_add(c);
                    add_token(srctok_pkg::KIND_VALUE, srctok_pkg::TOK_IDENT, c,
                              srctok_pkg::ERR_NONE, tok_line, tok_col);
                end
                else
                begin
                    close_token(ident_type());
                    lex_mode = srctok_pkg::MODE_IDLE;
                    open_token(c, ln, cl);
                end
            end
            srctok_pkg::MODE_MINUS:
            begin
                lex_mode = srctok_pkg::MODE_IDLE;
                if (c == ">")
                begin
                    close_token(srctok_pkg::TOK_ARROW);
                end
                else
                begin
                    // a minus on its own is a stray character at its own spot
                    add_token(srctok_pkg::KIND_ERROR, TYPE_NONE, "-",
                              srctok_pkg::ERR_UNEXPECTED, tok_line, tok_col);
                    open_token(c, ln, cl);
                end
            end
            default:
            begin
                lex_mode = srctok_pkg::MODE_IDLE;
                open_token(c, ln, cl);
            end
        endcase

        // position counters saturate
        if (c == "\n")
        begin
            if (cur_line != '1)
                cur_line++;
            cur_col = COL_W'(1);
        end
        else if (cur_col != '1)
        begin
            cur_col++;
        end

        // end of source flushes whatever is open and restarts the position
        if (item.end_of_source)
        begin
            case (lex_mode)
                srctok_pkg::MODE_STRING:
                    add_token(srctok_pkg::KIND_ERROR, TYPE_NONE, 8'h00,
                              srctok_pkg::ERR_STR_OPEN, tok_line, tok_col);
                srctok_pkg::MODE_NUMBER:
                    close_token(srctok_pkg::TOK_NUMBER);
                srctok_pkg::MODE_IDENT:
                    close_token(ident_type());
                srctok_pkg::MODE_MINUS:
                    add_token(srctok_pkg::KIND_ERROR, TYPE_NONE, "-",
                              srctok_pkg::ERR_UNEXPECTED, tok_line, tok_col);
                default: ;
            endcase
            lex_mode = srctok_pkg::MODE_IDLE;
            cur_line = LINE_W'(1);
            cur_col  = COL_W'(1);
        end

        if (byte_tokens.size() > 0)
        begin
            last = byte_tokens[byte_tokens.size() - 1];
            last.last_of_run = 1'b1;
            byte_tokens[byte_tokens.size() - 1] = last;
        end
        foreach (byte_tokens[i])
            pending_tokens.insert(pending_tokens.size(), byte_tokens[i]);
    endfunction

    // ------------------------------------------------------------------
    // output side: stall at random and check every record taken
    // ------------------------------------------------------------------

    initial
    begin
        tok_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            tok_stall <= !no_idle && ($urandom_range(0, 99) < 22);
        end
    end

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            failures++;
            if (failures <= 10)
                $display("mismatch in record %0d, %s: expected %0d, got %0d",
                         records_checked, name, want, got);
        end
    endtask

    task automatic check_record(input srctok_pkg::tok_item_t got);
        srctok_pkg::tok_item_t want;
        if (pending_tokens.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("record with nothing pending: kind %0d type %0d byte %0d err %0d",
                         got.kind, got.tok_type, got.value_byte, got.err_code);
        end
        else
        begin
            want = pending_tokens.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("tok_type", want.tok_type, got.tok_type);
            compare_field("value_byte", want.value_byte, got.value_byte);
            compare_field("err_code", want.err_code, got.err_code);
            compare_field("start_line", want.start_line, got.start_line);
            compare_field("start_col", want.start_col, got.start_col);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
            records_checked++;
        end
    endtask

    // values read right after the edge are the ones the edge sampled
    always @(posedge clk)
    begin
        if (rst_n && tok_valid && !tok_stall)
            check_record(tok_item);
    end

    // watchdog: too long without any transaction on either side
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (src_valid && !src_stall) || (tok_valid && !tok_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d records pending",
                         quiet, pending_tokens.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // one source byte, with random idle cycles before it
    task automatic send_byte(input logic [7:0] c, input logic eos);
        srctok_pkg::src_item_t item;
        item.ch            = c;
        item.end_of_source = eos;
        while (!no_idle && $urandom_range(0, 99) < 22)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= item;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        scan_byte(item);
        bytes_sent++;
        if (c != " " && c != "\t" && c != "\n")
            busy_bytes++;
    endtask

    function automatic void append_char(logic [7:0] c);
        source_text.insert(source_text.size(), c);
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append_char(s[i]);
    endtask

    // send the buffered text, optionally marking the last byte as end of source
    task automatic send_source(input bit eos_at_end);
        for (int i = 0; i < source_text.size(); i++)
            send_byte(source_text[i], eos_at_end && i == source_text.size() - 1);
        source_text.delete();
        if (eos_at_end)
            sources_sent++;
    endtask

    function automatic logic [7:0] pick_ident_char(bit first);
        return ident_chars[$urandom_range(0, first ? 52 : ident_chars.len() - 1)];
    endfunction

    // one lexical piece, mostly well formed, sometimes noise
    task automatic add_random_piece();
        int n;
        case ($urandom_range(0, 11))
            0, 1: add_text(kw_names[$urandom_range(0, 5)]);
            2:
            begin
                // keyword with a tail, or cut short
                if ($urandom_range(0, 1) == 0)
                begin
                    add_text(kw_names[$urandom_range(0, 5)]);
                    append_char(pick_ident_char(1'b0));
                end
                else
                begin
                    add_text(kw_names[$urandom_range(0, 5)].substr(0, 1));
                end
            end
            3:
            begin
                append_char(pick_ident_char(1'b1));
                n = $urandom_range(0, 7);
                repeat (n)
                    append_char(pick_ident_char(1'b0));
            end
            4:
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    append_char(8'("0" + $urandom_range(0, 9)));
            end
            5:
            begin
                // string, now and then with a newline or left open
                append_char("\"");
                n = $urandom_range(0, 5);
                repeat (n)
                begin
                    if ($urandom_range(0, 5) == 0)
                        append_char("\n");
                    else
                        append_char(8'($urandom_range(32, 126)));
                end
                if ($urandom_range(0, 7) != 0)
                    append_char("\"");
            end
            6, 7: append_char(punct_chars[$urandom_range(0, 4)]);
            8:    add_text("->");
            9:    append_char("-");
            default: append_char(8'($urandom_range(0, 255)));
        endcase
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // keyword, identifier with digit and underscore, all punctuation, arrow
    task automatic test_tokens_and_punctuation();
        add_text("ret(x_9)->{};");
        send_source(1'b0);
    endtask

    // newline inside a string, then a string still open at end of source
    task automatic test_string_errors();
        add_text("\"a\nb\"\"z");
        send_source(1'b1);
    endtask

    // lone minus, extreme bytes, tab, number flushed by end of source
    task automatic test_stray_bytes();
        add_text("-7");
        append_char(8'hFF);
        append_char(8'h00);
        add_text("\t9");
        send_source(1'b1);
    endtask

    // random sources of well-formed pieces mixed with noise
    task automatic test_random_sources();
        int target;
        int first_sent;
        first_sent = bytes_sent;
        while (bytes_sent - first_sent < RANDOM_BYTES)
        begin
            // a stretch in the middle runs with both sides at full rate
            no_idle = (bytes_sent - first_sent >= 50) && (bytes_sent - first_sent < 100);
            target = $urandom_range(6, 30);
            while (source_text.size() < target)
            begin
                if (source_text.size() > 0)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: append_char(" ");
                        6, 7: append_char(blank_chars[$urandom_range(1, 2)]);
                        default: ;
                    endcase
                end
                add_random_piece();
            end
            send_source(1'b1);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        src_valid <= 1'b0;
        src_item  <= '0;
        no_idle         = 1'b0;
        bytes_sent      = 0;
        busy_bytes      = 0;
        sources_sent    = 0;
        records_checked = 0;
        failures        = 0;
        reset_scanner();

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tokens_and_punctuation();
        test_string_errors();
        test_stray_bytes();
        test_random_sources();

        // last transaction taken, stop offering and let the records drain
        src_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("sent %0d source bytes (%0d non-blank) in %0d sources, checked %0d records",
                 bytes_sent, busy_bytes, sources_sent, records_checked);
        $display("keywords, arrows, lone minus, string errors and stray bytes under random stalls");
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
